@@ rtl/bernstein_subdivide_assert.svh @@
// Assertion macros shared by the de Casteljau subdivision block.
`ifndef BERNSTEIN_SUBDIVIDE_ASSERT_SVH
`define BERNSTEIN_SUBDIVIDE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BSUB_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSUB_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/bsub_pkg.sv @@
// Types and constants for the de Casteljau subdivision block.
package bsub_pkg;

   localparam int MAX_POINTS_DEF = 16;
   localparam int COEFF_W        = 32;
   localparam int T_W            = 17;
   localparam int IDX_W          = 4;
   localparam int PROD_W         = 51;
   localparam logic [T_W-1:0] T_ONE = 17'd65536;

   typedef struct packed {
      logic signed [COEFF_W-1:0] coeff_in;
      logic [T_W-1:0]            split_t;
      logic                      last_point;
   } req_type;

   typedef struct packed {
      logic                      half_select;
      logic [IDX_W-1:0]          point_index;
      logic signed [COEFF_W-1:0] coeff_out;
      logic                      last_result;
   } rsp_type;

   // Control of the shared blend datapath
   typedef struct packed {
      logic take_a;   // load left operand from the read port
      logic take_b;   // load right operand, form b - a
      logic mul;      // form t * (b - a) + half
      logic advance;  // right operand becomes next left operand
   } blend_ctl_type;

endpackage

@@ rtl/bsub_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bsub_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bsub_blend.sv @@
// Shared blend unit: a + floor((t*(b-a) + 32768) / 65536), one stage per step.
module bsub_blend (
   input  logic                                     clock,
   input  bsub_pkg::blend_ctl_type                  ctl,
   input  logic [bsub_pkg::T_W-1:0]                 split_t,
   input  logic [bsub_pkg::COEFF_W-1:0]             rd_data,
   output logic [bsub_pkg::COEFF_W-1:0]             result
);
   import bsub_pkg::*;

   logic signed [COEFF_W-1:0] a_ff, a_in;
   logic signed [COEFF_W-1:0] b_ff, b_in;
   logic signed [COEFF_W:0]   diff_ff, diff_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  quot;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      diff_in = diff_ff;
      prod_in = prod_ff;
      if (ctl.take_a) begin
         a_in = $signed(rd_data);
      end else if (ctl.advance) begin
         a_in = b_ff;
      end
      if (ctl.take_b) begin
         b_in    = $signed(rd_data);
         diff_in = $signed({rd_data[COEFF_W-1], rd_data}) - $signed({a_ff[COEFF_W-1], a_ff});
      end
      if (ctl.mul) begin
         prod_in = $signed({1'b0, split_t}) * diff_ff + PROD_W'(32768);
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
   end

   // arithmetic shift is floor division, which matches half-up rounding of both signs
   assign quot   = prod_ff >>> 16;
   assign result = COEFF_W'(a_ff + quot[COEFF_W-1:0]);

endmodule

@@ rtl/bernstein_subdivide.sv @@
// Top level: loads control points, runs the de Casteljau triangle, emits both halves.
//
//   channel  | ports                  | accepted when
//   request  | start, busy, req_data  | start && !busy
//   result   | rsp_valid, rsp_data    | every cycle rsp_valid is high
//
// A point that is not last is taken while busy stays low. After the last point,
// with n points (degree d = n-1), the run goes through the one shared blend unit
// and the point RAM's single read port, then emits 2n results. busy is high for
// the whole run. Reset clears the state, the point count and the held split; the
// RAMs are not cleared.
// Results cannot be stalled; each is shown for one cycle.
`include "bernstein_subdivide_assert.svh"

module bernstein_subdivide #(
   parameter int MAX_POINTS = bsub_pkg::MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bsub_pkg::req_type req_data,
   output logic              rsp_valid,
   output bsub_pkg::rsp_type rsp_data
);
   import bsub_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_ROW_START = 9'b000000010,
      ST_ROW_FIRST = 9'b000000100,
      ST_FETCH     = 9'b000001000,
      ST_DIFF      = 9'b000010000,
      ST_MUL       = 9'b000100000,
      ST_ADD       = 9'b001000000,
      ST_OUT_RD    = 9'b010000000,
      ST_OUT_EMIT  = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [AW-1:0]     deg_ff, deg_in;
   logic [AW-1:0]     i_ff, i_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [AW-1:0]     k_ff, k_in;
   logic              half_ff, half_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic               accept;
   logic               pt_we, lf_we;
   logic [AW-1:0]      pt_wa, lf_wa, pt_ra;
   logic [COEFF_W-1:0] pt_wd, lf_wd, pt_rd, lf_rd, blend_res;
   logic [AW+IDX_W-1:0] k_wide;
   blend_ctl_type      bctl;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign k_wide = {{IDX_W{1'b0}}, k_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      t_in         = t_ff;
      deg_in       = deg_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      half_in      = half_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pt_we        = 1'b0;
      pt_wa        = j_ff;
      pt_wd        = blend_res;
      pt_ra        = k_ff;
      lf_we        = 1'b0;
      lf_wa        = i_ff;
      lf_wd        = blend_res;
      bctl         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff < CW'(MAX_POINTS)) begin
                  pt_we    = 1'b1;
                  pt_wa    = count_ff[AW-1:0];
                  pt_wd    = req_data.coeff_in;
                  count_in = count_ff + CW'(1);
                  deg_in   = count_ff[AW-1:0];
               end else begin
                  deg_in   = AW'(MAX_POINTS - 1);
               end
               if (req_data.last_point) begin
                  t_in     = (req_data.split_t > T_ONE) ? T_ONE : req_data.split_t;
                  i_in     = '0;
                  state_in = ST_ROW_START;
               end
            end
         end
         ST_ROW_START: begin
            pt_ra    = '0;
            state_in = ST_ROW_FIRST;
         end
         ST_ROW_FIRST: begin
            bctl.take_a = 1'b1;
            if (i_ff == '0) begin
               // left[0] is the first loaded point
               lf_we = 1'b1;
               lf_wa = '0;
               lf_wd = pt_rd;
               if (deg_ff == '0) begin
                  k_in     = '0;
                  half_in  = 1'b0;
                  state_in = ST_OUT_RD;
               end else begin
                  i_in     = AW'(1);
                  state_in = ST_ROW_START;
               end
            end else begin
               j_in     = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            pt_ra    = j_ff + AW'(1);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            bctl.take_b = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            bctl.mul = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            bctl.advance = 1'b1;
            pt_we        = 1'b1;
            if (j_ff == '0) begin
               lf_we = 1'b1;
            end
            if (j_ff == deg_ff - i_ff) begin
               if (i_ff == deg_ff) begin
                  k_in     = '0;
                  half_in  = 1'b0;
                  state_in = ST_OUT_RD;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = ST_ROW_START;
               end
            end else begin
               j_in     = j_ff + AW'(1);
               state_in = ST_FETCH;
            end
         end
         ST_OUT_RD: begin
            pt_ra    = k_ff;
            state_in = ST_OUT_EMIT;
         end
         ST_OUT_EMIT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.half_select = half_ff;
            rsp_in.point_index = k_wide[IDX_W-1:0];
            rsp_in.coeff_out   = half_ff ? pt_rd : lf_rd;
            rsp_in.last_result = half_ff && (k_ff == deg_ff);
            if (k_ff == deg_ff) begin
               k_in = '0;
               if (half_ff) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  half_in  = 1'b1;
                  state_in = ST_OUT_RD;
               end
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         t_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         t_ff         <= t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deg_ff  <= deg_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      half_ff <= half_in;
      rsp_ff  <= rsp_in;
   end

   bsub_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_wa),
      .wr_data (pt_wd),
      .rd_addr (pt_ra),
      .rd_data (pt_rd)
   );

   bsub_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_POINTS)) u_left_ram (
      .clock   (clock),
      .wr_en   (lf_we),
      .wr_addr (lf_wa),
      .wr_data (lf_wd),
      .rd_addr (k_ff),
      .rd_data (lf_rd)
   );

   bsub_blend u_blend (
      .clock   (clock),
      .ctl     (bctl),
      .split_t (t_ff),
      .rd_data (pt_rd),
      .result  (blend_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BSUB_ASSERT_NEXT(a_emit_strobe, clock, reset, (state_ff == ST_OUT_EMIT), rsp_valid, "emit state did not raise the result strobe")
   `BSUB_ASSERT_NOW(a_last_closes_run, clock, reset, (rsp_valid && rsp_data.last_result), (rsp_data.half_select && (state_ff == ST_IDLE) && (count_ff == '0)), "final result without closing the run")
   `BSUB_ASSERT_NOW(a_triangle_bound, clock, reset, (state_ff == ST_ADD), (({1'b0, j_ff} + {1'b0, i_ff}) <= {1'b0, deg_ff}), "blend index beyond the triangle")

endmodule

@@ bench/bernstein_subdivide_check.sv @@
// Checker for the de Casteljau subdivision block: predicts both sub-polygons and compares results.
module bernstein_subdivide_check #(
   parameter int MAX_POINTS = bsub_pkg::MAX_POINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  bsub_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  bsub_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import bsub_pkg::*;

   logic signed [COEFF_W-1:0] polygon [MAX_POINTS];
   logic signed [COEFF_W-1:0] left_half [MAX_POINTS];
   int unsigned               loaded;
   rsp_type                   subdivided_q [$];

   // a + round_half_up(t * (b - a) / 2^16); the arithmetic shift floors both signs
   function automatic logic signed [COEFF_W-1:0] lerp_coeff(
      input logic signed [COEFF_W-1:0] a,
      input logic signed [COEFF_W-1:0] b,
      input logic [T_W-1:0]            t
   );
      longint prod;
      longint sum;
      prod = longint'(t) * (longint'(b) - longint'(a)) + 64'sd32768;
      sum  = longint'(a) + (prod >>> 16);
      return sum[COEFF_W-1:0];
   endfunction

   function automatic void subdivide_polygon(input logic [T_W-1:0] raw_t);
      logic [T_W-1:0] t;
      int             deg;
      rsp_type        r;
      t   = (raw_t > T_ONE) ? T_ONE : raw_t;
      deg = int'(loaded) - 1;
      left_half[0] = polygon[0];
      for (int i = 1; i <= deg; i++) begin
         for (int j = 0; j + i <= deg; j++)
            polygon[j] = lerp_coeff(polygon[j], polygon[j+1], t);
         left_half[i] = polygon[0];
      end
      // polygon now holds the right half
      for (int i = 0; i <= deg; i++) begin
         r.half_select = 1'b0;
         r.point_index = IDX_W'(i);
         r.coeff_out   = left_half[i];
         r.last_result = 1'b0;
         subdivided_q  = {subdivided_q, r};
      end
      for (int i = 0; i <= deg; i++) begin
         r.half_select = 1'b1;
         r.point_index = IDX_W'(i);
         r.coeff_out   = polygon[i];
         r.last_result = (i == deg);
         subdivided_q  = {subdivided_q, r};
      end
      loaded = 0;
   endfunction

   function automatic void check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         loaded     = 0;
         fail_count = 0;
         subdivided_q.delete();
      end else begin
         if (start && !busy) begin
            // extra points beyond the store are dropped
            if (loaded < MAX_POINTS) begin
               polygon[loaded] = req_data.coeff_in;
               loaded++;
            end
            if (req_data.last_point)
               subdivide_polygon(req_data.split_t);
         end
         if (rsp_valid) begin
            if (subdivided_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual half %0d index %0d coeff %0d",
                        $time, rsp_data.half_select, rsp_data.point_index, rsp_data.coeff_out);
               fail_count++;
            end else begin
               want = subdivided_q.pop_front();
               check_field("half_select", want.half_select, rsp_data.half_select);
               check_field("point_index", want.point_index, rsp_data.point_index);
               check_field("coeff_out", want.coeff_out, rsp_data.coeff_out);
               check_field("last_result", want.last_result, rsp_data.last_result);
            end
         end
      end
      pending_results = subdivided_q.size();
   end

endmodule

@@ bench/bernstein_subdivide_test.sv @@
// Testbench top for the de Casteljau subdivision block: clock, reset, requests and verdict.
module bernstein_subdivide_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bsub_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam int TOTAL_ITEMS = 250;   // 25 directed, the rest random

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fail_count;
   int pending_results;
   int idle_pct = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   bernstein_subdivide dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   bernstein_subdivide_check result_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ends the run if neither a request nor a result moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic signed [COEFF_W-1:0] random_coeff();
      case ($urandom_range(5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return COEFF_W'(int'($urandom_range(510)) - 255);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [T_W-1:0] random_split();
      case ($urandom_range(7))
         0: return '0;
         1: return T_ONE;
         2: return T_W'($urandom_range(131071, 65537));
         default: return T_W'($urandom_range(65536));
      endcase
   endfunction

   task automatic send_point(
      input logic signed [COEFF_W-1:0] coeff,
      input logic [T_W-1:0]            split,
      input logic                      last
   );
      req_type item;
      item.coeff_in   = coeff;
      item.split_t    = split;
      item.last_point = last;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic send_polygon(input int n_points);
      for (int i = 0; i < n_points; i++)
         send_point(random_coeff(), random_split(), i == n_points - 1);
   endtask

   initial begin
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // degree zero
      send_point(32'sh80000000, '0, 1'b1);
      // widest span at t of one
      send_point(32'sh7FFFFFFF, '0, 1'b0);
      send_point(32'sh80000000, T_ONE, 1'b1);
      // exact half step downward rounds up to zero
      send_point(32'sh0, '0, 1'b0);
      send_point(-32'sd1, 17'd32768, 1'b1);
      // split above one saturates
      send_point(32'sh0, '0, 1'b0);
      send_point(32'sh1, '0, 1'b0);
      send_point(32'sh0, 17'h1FFFF, 1'b1);
      // store overflow: the last point is dropped but still closes the polygon
      send_polygon(MAX_POINTS_DEF + 1);

      while (items_sent < TOTAL_ITEMS) begin
         case ((items_sent / 40) % 3)
            0: idle_pct = 0;
            1: idle_pct = 61;
            default: idle_pct = 14;
         endcase
         pick = $urandom_range(99);
         if (pick < 60)
            send_polygon($urandom_range(4, 1));
         else if (pick < 92)
            send_polygon($urandom_range(MAX_POINTS_DEF, 5));
         else
            send_polygon($urandom_range(MAX_POINTS_DEF + 4, MAX_POINTS_DEF + 1));
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
